// File: design/quad_motor_mixer_with_failsafe_macros.svh
// Assertion macros shared by the motor mixer RTL.
`ifndef QUAD_MOTOR_MIXER_WITH_FAILSAFE_MACROS_SVH
`define QUAD_MOTOR_MIXER_WITH_FAILSAFE_MACROS_SVH
`ifndef SYNTHESIS
`define QMM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("motor mixer check failed");
`define QMM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("motor mixer check failed");
`else
`define QMM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define QMM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: design/qmm_pkg.sv
// Types, constants and helpers shared by the motor mixer modules.
package qmm_pkg;

  localparam int SPEED_W    = 10;
  localparam int THR_W      = 10;
  localparam int DRIVE_W    = 12;
  localparam int HEIGHT_W   = 8;
  localparam int MODE_W     = 3;
  localparam int STEP_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int SUM_W      = 14;
  localparam int YAW_W      = 13;
  localparam int MOTORS     = 4;

  typedef logic [SPEED_W-1:0]         speed_t;
  typedef logic [MODE_W-1:0]          mode_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [YAW_W-1:0]    yaw_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

  localparam mode_t MODE_LOCKED     = 3'd0;
  localparam mode_t MODE_IDLE       = 3'd1;
  localparam mode_t MODE_NORMAL     = 3'd2;
  localparam mode_t MODE_FIX_HEIGHT = 3'd3;
  localparam mode_t MODE_FAIL       = 3'd4;

  localparam cfg_idx_t CFG_SPEED_LIMIT     = 2'd0;
  localparam cfg_idx_t CFG_THROTTLE_CUTOFF = 2'd1;
  localparam cfg_idx_t CFG_YAW_LIMIT       = 2'd2;
  localparam cfg_idx_t CFG_RAMP_STEP       = 2'd3;

  localparam speed_t            RST_SPEED_LIMIT     = 10'd700;
  localparam logic [THR_W-1:0]  RST_THROTTLE_CUTOFF = 10'd100;
  localparam logic [9:0]        RST_YAW_LIMIT       = 10'd100;
  localparam logic [STEP_W-1:0] RST_RAMP_STEP       = 8'd2;

  typedef struct packed {
    speed_t             speed_limit;
    logic [THR_W-1:0]   throttle_cutoff;
    logic [9:0]         yaw_limit;
    logic [STEP_W-1:0]  ramp_step;
  } cfg_t;

  typedef struct packed {
    mode_t                mode;
    logic [THR_W-1:0]     throttle;
    logic [DRIVE_W-1:0]   pitch_drive;
    logic [DRIVE_W-1:0]   roll_drive;
    logic [DRIVE_W-1:0]   yaw_drive;
    logic [HEIGHT_W-1:0]  height_drive;
  } tick_t;

  // Saturates a signed wide speed into the range 0 to the limit.
  function automatic speed_t sat_speed(sum_t s, speed_t lim);
    sum_t lim_w;
    lim_w = sum_t'({{(SUM_W-SPEED_W){1'b0}}, lim});
    if (s < 0) begin
      return '0;
    end else if (s > lim_w) begin
      return lim;
    end else begin
      return s[SPEED_W-1:0];
    end
  endfunction

endpackage

// File: design/qmm_cfg_regs.sv
// Configuration registers of the motor mixer.
module qmm_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  qmm_pkg::cfg_idx_t                    cfg_index,
  input  logic [qmm_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  output qmm_pkg::cfg_t                        cfg
);

  qmm_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_limit     <= qmm_pkg::RST_SPEED_LIMIT;
      cfg_r.throttle_cutoff <= qmm_pkg::RST_THROTTLE_CUTOFF;
      cfg_r.yaw_limit       <= qmm_pkg::RST_YAW_LIMIT;
      cfg_r.ramp_step       <= qmm_pkg::RST_RAMP_STEP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qmm_pkg::CFG_SPEED_LIMIT:     cfg_r.speed_limit     <= cfg_wdata;
        qmm_pkg::CFG_THROTTLE_CUTOFF: cfg_r.throttle_cutoff <= cfg_wdata;
        qmm_pkg::CFG_YAW_LIMIT:       cfg_r.yaw_limit       <= cfg_wdata;
        qmm_pkg::CFG_RAMP_STEP:       cfg_r.ramp_step <= cfg_wdata[qmm_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: design/qmm_mix.sv
// Single-pass mixing datapath: mode decode, X mix, fail ramp, saturation and cutoff.
module qmm_mix (
  input  qmm_pkg::tick_t                           tick,
  input  qmm_pkg::cfg_t                            cfg,
  input  qmm_pkg::speed_t [qmm_pkg::MOTORS-1:0]    cur_speed,
  output qmm_pkg::speed_t [qmm_pkg::MOTORS-1:0]    nxt_speed,
  output logic                                     lock
);

  localparam int SW = qmm_pkg::SUM_W;
  localparam int DW = qmm_pkg::DRIVE_W;
  localparam int HW = qmm_pkg::HEIGHT_W;
  localparam int YW = qmm_pkg::YAW_W;

  qmm_pkg::yaw_t yaw_lim;
  qmm_pkg::yaw_t yaw_ext;
  qmm_pkg::yaw_t yaw_clamped;
  qmm_pkg::sum_t thr;
  qmm_pkg::sum_t pitch;
  qmm_pkg::sum_t roll;
  qmm_pkg::sum_t yaw;
  qmm_pkg::sum_t height;
  qmm_pkg::sum_t step;
  qmm_pkg::sum_t mix   [qmm_pkg::MOTORS];
  qmm_pkg::sum_t ramp  [qmm_pkg::MOTORS];
  qmm_pkg::sum_t raw   [qmm_pkg::MOTORS];
  logic          ramp_done;
  logic          is_fail;
  logic          cutoff;

  always_comb begin
    yaw_lim = qmm_pkg::yaw_t'({{(YW-10){1'b0}}, cfg.yaw_limit});
    yaw_ext = {{(YW-DW){tick.yaw_drive[DW-1]}}, tick.yaw_drive};
    if (yaw_ext < -yaw_lim) begin
      yaw_clamped = -yaw_lim;
    end else if (yaw_ext > yaw_lim) begin
      yaw_clamped = yaw_lim;
    end else begin
      yaw_clamped = yaw_ext;
    end

    thr   = qmm_pkg::sum_t'({{(SW-qmm_pkg::THR_W){1'b0}}, tick.throttle});
    pitch = {{(SW-DW){tick.pitch_drive[DW-1]}}, tick.pitch_drive};
    roll  = {{(SW-DW){tick.roll_drive[DW-1]}}, tick.roll_drive};
    yaw   = {{(SW-YW){yaw_clamped[YW-1]}}, yaw_clamped};
    if (tick.mode == qmm_pkg::MODE_FIX_HEIGHT) begin
      height = {{(SW-HW){tick.height_drive[HW-1]}}, tick.height_drive};
    end else begin
      height = '0;
    end

    // Motor order: front left, rear left, front right, rear right.
    mix[0] = thr + pitch - roll + yaw + height;
    mix[1] = thr - pitch - roll - yaw + height;
    mix[2] = thr + pitch + roll - yaw + height;
    mix[3] = thr - pitch + roll + yaw + height;

    step      = qmm_pkg::sum_t'({{(SW-qmm_pkg::STEP_W){1'b0}}, cfg.ramp_step});
    ramp_done = 1'b1;
    for (int i = 0; i < qmm_pkg::MOTORS; i++) begin
      ramp[i] = qmm_pkg::sum_t'({{(SW-qmm_pkg::SPEED_W){1'b0}}, cur_speed[i]}) - step;
      if (ramp[i] > 0) begin
        ramp_done = 1'b0;
      end
    end

    is_fail = 1'b0;
    unique case (tick.mode) inside
      qmm_pkg::MODE_LOCKED, qmm_pkg::MODE_IDLE: begin
        for (int i = 0; i < qmm_pkg::MOTORS; i++) raw[i] = '0;
      end
      qmm_pkg::MODE_NORMAL, qmm_pkg::MODE_FIX_HEIGHT: begin
        for (int i = 0; i < qmm_pkg::MOTORS; i++) raw[i] = mix[i];
      end
      qmm_pkg::MODE_FAIL: begin
        is_fail = 1'b1;
        for (int i = 0; i < qmm_pkg::MOTORS; i++) raw[i] = ramp[i];
      end
      default: begin
        for (int i = 0; i < qmm_pkg::MOTORS; i++) begin
          raw[i] = qmm_pkg::sum_t'({{(SW-qmm_pkg::SPEED_W){1'b0}}, cur_speed[i]});
        end
      end
    endcase

    // The lock request looks at the ramped speeds before the cutoff.
    lock   = is_fail && ramp_done;
    cutoff = tick.throttle < cfg.throttle_cutoff;
    for (int i = 0; i < qmm_pkg::MOTORS; i++) begin
      nxt_speed[i] = cutoff ? '0 : qmm_pkg::sat_speed(raw[i], cfg.speed_limit);
    end
  end

endmodule

// File: design/quad_motor_mixer_with_failsafe.sv
// Quadcopter X-frame motor mixer with fail-mode ramp-down, top level.
// A request is held in the input register; its result is then written into the
// stored motor speeds. Throughput: one request per cycle unless out_ready stalls
// the result; the input and result registers form a two-stage pipeline, and the
// stored speeds double as the result register. Reset (synchronous, active low)
// clears both valid flags and the speeds; config registers load their defaults.
`include "quad_motor_mixer_with_failsafe_macros.svh"

module quad_motor_mixer_with_failsafe (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [qmm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [qmm_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [qmm_pkg::MODE_W-1:0]            in_mode,
  input  logic [qmm_pkg::THR_W-1:0]             in_throttle,
  input  logic signed [qmm_pkg::DRIVE_W-1:0]    in_pitch_drive,
  input  logic signed [qmm_pkg::DRIVE_W-1:0]    in_roll_drive,
  input  logic signed [qmm_pkg::DRIVE_W-1:0]    in_yaw_drive,
  input  logic signed [qmm_pkg::HEIGHT_W-1:0]   in_height_drive,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [qmm_pkg::SPEED_W-1:0]           out_front_left_speed,
  output logic [qmm_pkg::SPEED_W-1:0]           out_rear_left_speed,
  output logic [qmm_pkg::SPEED_W-1:0]           out_front_right_speed,
  output logic [qmm_pkg::SPEED_W-1:0]           out_rear_right_speed,
  output logic                                  out_lock_request
);

  qmm_pkg::cfg_t                          cfg;
  qmm_pkg::tick_t                         tick_r;
  qmm_pkg::tick_t                         tick_nxt;
  logic                                   s1_valid_r;
  logic                                   s1_valid_nxt;
  logic                                   out_valid_r;
  logic                                   out_valid_nxt;
  qmm_pkg::speed_t [qmm_pkg::MOTORS-1:0]  speed_r;
  qmm_pkg::speed_t [qmm_pkg::MOTORS-1:0]  speed_nxt;
  logic                                   lock_r;
  logic                                   lock_nxt;
  logic                                   in_accept;
  logic                                   advance;

  qmm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  qmm_mix u_mix (
    .tick      (tick_r),
    .cfg       (cfg),
    .cur_speed (speed_r),
    .nxt_speed (speed_nxt),
    .lock      (lock_nxt)
  );

  // The input stage moves on whenever the result register is empty or being drained.
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    tick_nxt.mode         = in_mode;
    tick_nxt.throttle     = in_throttle;
    tick_nxt.pitch_drive  = in_pitch_drive;
    tick_nxt.roll_drive   = in_roll_drive;
    tick_nxt.yaw_drive    = in_yaw_drive;
    tick_nxt.height_drive = in_height_drive;

    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      speed_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        speed_r <= speed_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      tick_r <= tick_nxt;
    end
    if (advance) begin
      lock_r <= lock_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_front_left_speed  = speed_r[0];
  assign out_rear_left_speed   = speed_r[1];
  assign out_front_right_speed = speed_r[2];
  assign out_rear_right_speed  = speed_r[3];
  assign out_lock_request      = lock_r;

  `QMM_ASSERT_IMP(a_lock_means_stopped, clk, rst_n, out_valid_r && lock_r, speed_r == '0)
  `QMM_ASSERT_IMP(a_full_and_stalled_blocks, clk, rst_n, s1_valid_r && out_valid_r && !out_ready, !in_ready)
  `QMM_ASSERT_IMP(a_empty_result_takes_request, clk, rst_n, !out_valid_r, in_ready)
  `QMM_ASSERT_NXT(a_advance_fills_result, clk, rst_n, advance, out_valid_r)

endmodule
